// ===== rtl/wkh_pkg.sv =====
// Shared types and constants for the windowed knob hysteresis scaler.
package wkh_pkg;

  // The window width register and the scaled result are fixed at 10 bits.
  localparam int WIDTH_BITS = 10;
  localparam int QUOT_BITS  = 10;
  localparam int DIV_BITS   = 11;

  // The scale span is 1024; the divisor is the span minus the window width.
  localparam logic [DIV_BITS-1:0]   SCALE_SPAN    = 11'd1024;
  localparam logic [QUOT_BITS-1:0]  OUT_MAX       = 10'd1023;
  localparam logic [WIDTH_BITS-1:0] WIDTH_DEFAULT = 10'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // take the request, update the window, start the divide
    logic step;  // one restoring divide step
    logic push;  // move the result into the output register
  } wkh_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic out_full;  // output register holds a result that is not taken this cycle
  } wkh_sts_t;

endpackage

// ===== rtl/wkh_ctrl.sv =====
// Controller state machine that sequences window update, divide and result hand-off.
module wkh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              cfg_ready_o,
  output wkh_pkg::wkh_cmd_t cmd_o,
  input  wkh_pkg::wkh_sts_t sts_i
);
  import wkh_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int CNT_BITS = $clog2(QUOT_BITS);

  logic [1:0]          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(QUOT_BITS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The width register is only written between requests, never in the cycle
  // a request is taken, so a request always sees one width throughout.
  assign cfg_ready_o = (state_q == ST_IDLE) && !in_valid_i;

  // State and step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/wkh_dp.sv =====
// Datapath: width register, window edge, restoring divider and output register.
module wkh_dp #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [SAMPLE_BITS-1:0]            sample_value_i,
  input  logic                              cfg_we_i,
  input  logic [wkh_pkg::WIDTH_BITS-1:0]    window_width_i,
  input  wkh_pkg::wkh_cmd_t                 cmd_i,
  output wkh_pkg::wkh_sts_t                 sts_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [wkh_pkg::QUOT_BITS-1:0]     scaled_value_o,
  output logic                              window_moved_o
);
  import wkh_pkg::*;

  // Wide enough for the upper edge and for comparing against the divisor.
  localparam int EW = ((SAMPLE_BITS > WIDTH_BITS) ? SAMPLE_BITS : WIDTH_BITS) + 1;

  logic [WIDTH_BITS-1:0]  width_q;
  logic [SAMPLE_BITS-1:0] lower_q, lower_d;
  logic                   moved_q, moved_d;
  logic                   sat_q, sat_d;
  logic [DIV_BITS-1:0]    rem_q, rem_d;
  logic [QUOT_BITS-1:0]   quot_q, quot_d;
  logic                   out_valid_q;
  logic [QUOT_BITS-1:0]   out_value_q;
  logic                   out_moved_q;

  logic [EW-1:0]       sample_w, width_w, lower_w, upper_w, edge_w;
  logic [DIV_BITS-1:0] divisor;
  logic [DIV_BITS:0]   rem_sh;
  logic                sub_ok;

  // Window update on a new request: upward test first, then downward.
  always_comb begin
    sample_w = EW'(sample_value_i);
    width_w  = EW'(width_q);
    lower_w  = EW'(lower_q);
    upper_w  = lower_w + width_w;
    edge_w   = lower_w;
    moved_d  = 1'b0;
    if (sample_w > upper_w) begin
      edge_w  = (sample_w >= width_w) ? (sample_w - width_w) : '0;
      moved_d = 1'b1;
    end
    if (sample_w < edge_w) begin
      edge_w  = sample_w;
      moved_d = 1'b1;
    end
    lower_d = edge_w[SAMPLE_BITS-1:0];
  end

  // The quotient exceeds the output range exactly when edge >= divisor.
  assign divisor = SCALE_SPAN - DIV_BITS'(width_q);
  assign sat_d   = (EW'(lower_d) >= EW'(divisor));

  // One restoring divide step; dividend bits below the edge are zero.
  assign rem_sh = {rem_q, 1'b0};
  assign sub_ok = (rem_sh >= {1'b0, divisor});

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    if (cmd_i.load) begin
      rem_d  = DIV_BITS'(EW'(lower_d));
      quot_d = '0;
    end else if (cmd_i.step) begin
      rem_d  = sub_ok ? DIV_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[DIV_BITS-1:0];
      quot_d = {quot_q[QUOT_BITS-2:0], sub_ok};
    end
  end

  // Configuration and window state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_DEFAULT;
      lower_q <= '0;
    end else begin
      if (cfg_we_i) begin
        width_q <= window_width_i;
      end
      if (cmd_i.load) begin
        lower_q <= lower_d;
      end
    end
  end

  // Divider working registers.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (cmd_i.load) begin
      moved_q <= moved_d;
      sat_q   <= sat_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload, saturated when the quotient would overflow.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_value_q <= sat_q ? OUT_MAX : quot_q;
      out_moved_q <= moved_q;
    end
  end

  assign sts_o.out_full = out_valid_q && out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign scaled_value_o = out_value_q;
  assign window_moved_o = out_moved_q;

endmodule

// ===== rtl/windowed_knob_hysteresis_scaler_core.sv =====
// Top level of the windowed knob hysteresis scaler.
// Sequence per request: window update at acceptance, 10 restoring divide steps, then the
// move into the output register.
// A new request is taken only after the current result moves into the output register;
// a stalled output holds the finished request and the input until the result is taken.
// Reset: window lower edge clears to 0 and the window width returns to 16.
module windowed_knob_hysteresis_scaler_core #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [SAMPLE_BITS-1:0]         sample_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [wkh_pkg::QUOT_BITS-1:0]  scaled_value_o,
  output logic                           window_moved_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wkh_pkg::WIDTH_BITS-1:0] window_width_i
);
  import wkh_pkg::*;

  wkh_cmd_t cmd;
  wkh_sts_t sts;

  wkh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_ready_o(cfg_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  wkh_dp #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_value_i(sample_value_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .window_width_i(window_width_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scaled_value_o(scaled_value_o),
    .window_moved_o(window_moved_o)
  );

  // An accepted request keeps the input stalled while the divide runs.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a request was accepted");

  // A new result only appears after a request was taken.
  a_result_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while no request was in flight");

  // A result is never pushed while a request is being taken or configuration written.
  a_push_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (in_stall_o && !cfg_ready_o))
    else $error("result pushed while the block was idle");

endmodule

// ===== tb/windowed_knob_hysteresis_scaler_core_tb.sv =====
// Self-checking testbench for the windowed knob hysteresis scaler core.
module windowed_knob_hysteresis_scaler_core_tb;
  import wkh_pkg::*;

  localparam int KNOB_BITS   = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_TAIL  = 24;
  localparam int HOLD_LEN    = 400;

  typedef struct packed {
    logic [QUOT_BITS-1:0] scaled;
    logic                 moved;
  } knob_result_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [KNOB_BITS-1:0]  sample_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [QUOT_BITS-1:0]  scaled_value_o;
  logic                  window_moved_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [WIDTH_BITS-1:0] window_width_i = '0;

  // Predictor state of the window and its width register.
  logic [KNOB_BITS-1:0]  model_lower_edge;
  logic [WIDTH_BITS-1:0] model_width;
  knob_result_t          pending_results[$];
  int unsigned           error_count  = 0;
  int unsigned           cycle_count  = 0;
  int unsigned           send_idle_pct  = 0;
  int unsigned           recv_stall_pct = 0;
  int unsigned           hold_gen     = 0;
  int unsigned           hold_seen    = 0;
  int unsigned           hold_left    = 0;
  int                    knob_pos     = 512;

  windowed_knob_hysteresis_scaler_core #(
    .SAMPLE_BITS(KNOB_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_value_i (sample_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .scaled_value_o (scaled_value_o),
    .window_moved_o (window_moved_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .window_width_i (window_width_i)
  );

  always #5 clk_i = ~clk_i;

  // Apply one sample to the window model and return the result it should produce.
  function automatic knob_result_t predict_window_step(input logic [KNOB_BITS-1:0] sample);
    logic [KNOB_BITS:0] upper;
    logic [20:0]        quotient;
    knob_result_t       res;
    res.moved = 1'b0;
    upper = {1'b0, model_lower_edge} + {1'b0, model_width};
    // The upward test comes first; the upper edge is kept one bit wider.
    if ({1'b0, sample} > upper) begin
      model_lower_edge = (sample >= model_width) ? sample - model_width : '0;
      res.moved = 1'b1;
    end
    if (sample < model_lower_edge) begin
      model_lower_edge = sample;
      res.moved = 1'b1;
    end
    quotient = {model_lower_edge, 10'b0} / (SCALE_SPAN - {1'b0, model_width});
    res.scaled = (quotient > 21'(OUT_MAX)) ? OUT_MAX : quotient[QUOT_BITS-1:0];
    return res;
  endfunction

  // Knob-like motion most of the time, with full-range jumps mixed in.
  function automatic logic [KNOB_BITS-1:0] next_knob_sample();
    if ($urandom_range(99) < 20) begin
      knob_pos = $urandom_range(1023);
    end else begin
      knob_pos = knob_pos + $urandom_range(80) - 40;
      if (knob_pos < 0) knob_pos = 0;
      if (knob_pos > 1023) knob_pos = 1023;
    end
    return knob_pos[KNOB_BITS-1:0];
  endfunction

  // Offer one sample request, holding it until the block takes it.
  task automatic send_sample(input logic [KNOB_BITS-1:0] sample);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= sample;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_window_step(sample));
  endtask

  // Stop offering requests and wait for every expected result.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write the window width once the block is idle.
  task automatic write_window_width(input logic [WIDTH_BITS-1:0] width);
    drain_results();
    cfg_valid_i    <= 1'b1;
    window_width_i <= width;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    model_width = width;
  endtask

  // Reset width of 16: no move, moves up and down, edge at the top of the range.
  task automatic test_default_window();
    send_sample(10'd0);
    send_sample(10'd16);
    send_sample(10'd17);
    send_sample(10'd1023);
    send_sample(10'd1023);
    send_sample(10'd1006);
    send_sample(10'd0);
    drain_results();
  endtask

  // Zero width follows every sample; full width saturates any nonzero edge and cannot move up.
  task automatic test_width_extremes();
    write_window_width(10'd0);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd512);
    send_sample(10'd512);
    send_sample(10'd1);
    write_window_width(10'd1023);
    send_sample(10'd1023);
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd5);
    drain_results();
  endtask

  // A new width moves the upper edge at once but leaves the window in place.
  task automatic test_width_change();
    write_window_width(10'd16);
    send_sample(10'd600);
    write_window_width(10'd100);
    send_sample(10'd650);
    send_sample(10'd690);
    write_window_width(10'd1);
    send_sample(10'd591);
    drain_results();
  endtask

  // Random knob traffic under one idling pattern, at two window widths.
  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned stall_pct,
                                     input logic [WIDTH_BITS-1:0] width_a,
                                     input logic [WIDTH_BITS-1:0] width_b);
    write_window_width(width_a);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    repeat (100) send_sample(next_knob_sample());
    write_window_width(width_b);
    repeat (100) send_sample(next_knob_sample());
    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    write_window_width(10'd40);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_gen++;
    repeat (40) send_sample(next_knob_sample());
    drain_results();
  endtask

  // Receiver stall, with a long hold-off counted here when requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_seen   <= 0;
    end else if (hold_seen != hold_gen) begin
      hold_seen   <= hold_gen;
      hold_left   <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    knob_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: scaled_value %0d, window_moved %0d",
               scaled_value_o, window_moved_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (scaled_value_o !== want.scaled) begin
          $error("scaled_value mismatch: expected %0d, actual %0d", want.scaled,
                 scaled_value_o);
          error_count++;
        end
        if (window_moved_o !== want.moved) begin
          $error("window_moved mismatch: expected %0d, actual %0d", want.moved,
                 window_moved_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    model_lower_edge = '0;
    model_width      = WIDTH_DEFAULT;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_window();
    test_width_extremes();
    test_width_change();
    test_random_traffic(0, 0, 10'($urandom_range(2, 64)), 10'd0);
    test_random_traffic(71, 0, 10'd1023, 10'd300);
    test_random_traffic(0, 71, 10'd1022, 10'd1);
    test_random_traffic(28, 28, 10'($urandom_range(1023)), 10'd16);
    test_output_backpressure();

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
